/* rtl/vspg_pkg.sv */
// Shared types and constants for the velocity step pulse generator.
// No dependencies; used by vspg_core and velocity_step_pulse_generator_top.

package vspg_pkg;

  localparam int unsigned SPEED_W = 24;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned POS_W   = 32;

  // signed speed times zero-extended elapsed time
  localparam int unsigned DIFF_W = SPEED_W + TIME_W + 1;

  // 1000 ms per second times 2^8 for the speed fraction
  localparam int unsigned SCALE = 256000;

  // 250 microsteps per second in Q15.8
  localparam logic signed [SPEED_W-1:0] FAST_POS_Q8 = 24'sd64000;
  localparam logic signed [SPEED_W-1:0] FAST_NEG_Q8 = -24'sd64000;

  typedef enum logic [1:0] {
    OP_POLL    = 2'd0,
    OP_RESTART = 2'd1,
    OP_LOAD    = 2'd2
  } op_e;

  typedef enum logic {
    CFG_SPEED    = 1'b0,
    CFG_POLARITY = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic             step_pulse;
    logic             dir_level;
    logic             microstep_select;
    logic [POS_W-1:0] position;
  } result_t;

endpackage

/* rtl/vspg_core.sv */
// Step decision and motion state (issued steps, start time, position, direction, mode).
// Depends on vspg_pkg.

module vspg_core #(
  parameter int unsigned MICROSTEPS_PER_FULL = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  fire_i,
  input  logic [1:0]                            op_i,
  input  logic [vspg_pkg::TIME_W-1:0]           now_ms_i,
  input  logic signed [vspg_pkg::POS_W-1:0]     position_value_i,
  input  logic signed [vspg_pkg::SPEED_W-1:0]   speed_q8_i,
  input  logic                                  direction_polarity_i,
  output vspg_pkg::result_t                     result_o
);

  localparam int unsigned DiffW = vspg_pkg::DIFF_W;
  localparam logic signed [DiffW-1:0] ScaleS = DiffW'(vspg_pkg::SCALE);
  localparam logic signed [DiffW-1:0] ThreshFull =
    DiffW'(MICROSTEPS_PER_FULL * vspg_pkg::SCALE);
  localparam logic signed [DiffW-1:0] ThreshMicro = DiffW'(vspg_pkg::SCALE);
  localparam logic [vspg_pkg::POS_W-1:0] AmountFull =
    vspg_pkg::POS_W'(MICROSTEPS_PER_FULL);

  logic signed [vspg_pkg::POS_W-1:0]  issued_q, issued_d;
  logic [vspg_pkg::TIME_W-1:0]        start_q, start_d;
  logic [vspg_pkg::POS_W-1:0]         pos_q, pos_d;
  logic                               fwd_q, fwd_d;
  logic                               full_q, full_d;
  logic                               dir_q, dir_d;

  logic [vspg_pkg::TIME_W-1:0]        elapsed;
  logic signed [vspg_pkg::TIME_W:0]   elapsed_s;
  logic signed [DiffW-1:0]            owed;
  logic signed [DiffW-1:0]            issued_scaled;
  logic signed [DiffW-1:0]            diff;
  logic signed [DiffW-1:0]            thresh;
  logic [vspg_pkg::POS_W-1:0]         amount;
  logic                               fast;
  logic                               step_back;
  logic                               step_fwd;
  logic                               pulse;

  always_comb begin
    elapsed       = now_ms_i - start_q;
    elapsed_s     = {1'b0, elapsed};
    owed          = DiffW'(speed_q8_i) * DiffW'(elapsed_s);
    issued_scaled = DiffW'(issued_q) * ScaleS;
    diff          = owed - issued_scaled;
    fast          = (speed_q8_i > vspg_pkg::FAST_POS_Q8) ||
                    (speed_q8_i < vspg_pkg::FAST_NEG_Q8);
    thresh        = fast ? ThreshFull : ThreshMicro;
    amount        = fast ? AmountFull : vspg_pkg::POS_W'(1);
    step_back     = diff < -thresh;
    step_fwd      = diff > thresh;
  end

  always_comb begin
    issued_d = issued_q;
    start_d  = start_q;
    pos_d    = pos_q;
    fwd_d    = fwd_q;
    full_d   = full_q;
    dir_d    = dir_q;
    pulse    = 1'b0;
    unique case (op_i)
      vspg_pkg::OP_POLL: begin
        if (step_back || step_fwd) begin
          pulse  = 1'b1;
          full_d = fast;
          // pin only moves on a reversal
          if (step_fwd != fwd_q) begin
            fwd_d = step_fwd;
            dir_d = direction_polarity_i ? step_fwd : !step_fwd;
          end
          if (step_fwd) begin
            pos_d    = pos_q + amount;
            issued_d = issued_q + signed'(amount);
          end else begin
            pos_d    = pos_q - amount;
            issued_d = issued_q - signed'(amount);
          end
        end
      end
      vspg_pkg::OP_RESTART: begin
        issued_d = '0;
        start_d  = now_ms_i;
      end
      vspg_pkg::OP_LOAD: begin
        pos_d = position_value_i;
      end
      default: begin
        // unused code: report state only
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issued_q <= '0;
      start_q  <= '0;
      pos_q    <= '0;
      fwd_q    <= 1'b1;
      full_q   <= 1'b0;
      dir_q    <= 1'b1;
    end else if (fire_i) begin
      issued_q <= issued_d;
      start_q  <= start_d;
      pos_q    <= pos_d;
      fwd_q    <= fwd_d;
      full_q   <= full_d;
      dir_q    <= dir_d;
    end
  end

  assign result_o.step_pulse       = pulse;
  assign result_o.dir_level        = dir_d;
  assign result_o.microstep_select = !full_d;
  assign result_o.position         = pos_d;

endmodule

/* rtl/velocity_step_pulse_generator_top.sv */
// Top level of the velocity step pulse generator: config registers, input and result registers.
// Depends on vspg_pkg and vspg_core.
//
//   channel | direction | handshake         | payload
//   --------+-----------+-------------------+----------------------------------------------
//   cfg     | in        | valid / ready     | cfg_index_i, cfg_data_i
//   in      | in        | valid / stall     | operation_i, now_ms_i, position_value_i
//   out     | out       | valid / stall     | step_pulse_o, dir_level_o, microstep_select_o,
//           |           |                   | position_o
//
// one transaction per cycle sustained while the output channel is not stalled
// stage 1 registers the input; the step decision (one 24x33 multiply, subtract, compare) runs
// between that register and the result register, and updates the motion state in the same edge
// reset clears the motion state to forward, microstep mode, position zero, speed zero, polarity 1
// a stalled result holds in the result register while stage 1 still takes one more transaction
// cfg writes are always ready and take effect on the next cycle

module velocity_step_pulse_generator_top #(
  parameter int unsigned MICROSTEPS_PER_FULL = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic                                cfg_index_i,
  input  logic [vspg_pkg::SPEED_W-1:0]        cfg_data_i,
  // input items
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          operation_i,
  input  logic [vspg_pkg::TIME_W-1:0]         now_ms_i,
  input  logic signed [vspg_pkg::POS_W-1:0]   position_value_i,
  // results
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                step_pulse_o,
  output logic                                dir_level_o,
  output logic                                microstep_select_o,
  output logic signed [vspg_pkg::POS_W-1:0]   position_o
);

  // configuration registers
  logic signed [vspg_pkg::SPEED_W-1:0] speed_q;
  logic                                polarity_q;

  // stage 1: registered input transaction
  logic                                s1_valid_q;
  logic [1:0]                          s1_op_q;
  logic [vspg_pkg::TIME_W-1:0]         s1_now_q;
  logic signed [vspg_pkg::POS_W-1:0]   s1_pos_q;

  // result register
  logic                                out_valid_q;
  vspg_pkg::result_t                   result_q;
  vspg_pkg::result_t                   core_res;

  logic out_free;   // result register can take a new result
  logic fire;       // stage 1 moves into the result register
  logic in_take;    // input transaction accepted

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q    <= '0;
      polarity_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        vspg_pkg::CFG_SPEED:    speed_q    <= signed'(cfg_data_i);
        vspg_pkg::CFG_POLARITY: polarity_q <= cfg_data_i[0];
        default:                ;
      endcase
    end
  end

  // the result register frees up when it is empty or being taken this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  // payload of stage 1 needs no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_op_q  <= operation_i;
      s1_now_q <= now_ms_i;
      s1_pos_q <= position_value_i;
    end
  end

  vspg_core #(
    .MICROSTEPS_PER_FULL (MICROSTEPS_PER_FULL)
  ) u_core (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .fire_i               (fire),
    .op_i                 (s1_op_q),
    .now_ms_i             (s1_now_q),
    .position_value_i     (s1_pos_q),
    .speed_q8_i           (speed_q),
    .direction_polarity_i (polarity_q),
    .result_o             (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      result_q <= core_res;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign step_pulse_o       = result_q.step_pulse;
  assign dir_level_o        = result_q.dir_level;
  assign microstep_select_o = result_q.microstep_select;
  assign position_o         = signed'(result_q.position);

  // the input side only stalls when stage 1 holds a transaction
  a_stall_needs_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with stage 1 empty");

  // a transaction that moves on always shows up as a result
  a_fire_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("result register empty after stage 1 advanced");

  // a held stage 1 transaction is never dropped
  a_s1_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !fire |=> s1_valid_q)
    else $error("stage 1 transaction lost");

endmodule

/* tb/sv/velocity_step_pulse_generator_top_tb.sv */
// Self-checking testbench for velocity_step_pulse_generator_top: directed and random commands,
// a command-level motion predictor and an in-order result check. Depends on vspg_pkg and the RTL.
`timescale 1ns / 100ps

module velocity_step_pulse_generator_top_tb;

  localparam int unsigned MICROSTEPS = 16;

  // unused operation code: the block leaves its state alone and reports it
  localparam logic [1:0] OP_SPARE = 2'd3;

  // exact owed-step comparison: 1000 ms times 2^8 for the speed fraction
  localparam longint MS_Q8_SCALE = 256000;
  localparam longint FULL_LIMIT = MICROSTEPS;

  // margin after the last report before a register write
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES = 8;
  // cycles with no transaction on either data channel before the run is declared hung
  localparam int WATCHDOG_LIMIT = 2000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_index_i = 1'b0;
  logic [vspg_pkg::SPEED_W-1:0] cfg_data_i = '0;

  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] operation_i = 2'd0;
  logic [vspg_pkg::TIME_W-1:0] now_ms_i = '0;
  logic signed [vspg_pkg::POS_W-1:0] position_value_i = '0;

  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic step_pulse_o;
  logic dir_level_o;
  logic microstep_select_o;
  logic signed [vspg_pkg::POS_W-1:0] position_o;

  // predicted motion state and register copies
  logic signed [vspg_pkg::SPEED_W-1:0] speed_reg = '0;
  logic polarity_reg = 1'b1;
  logic [31:0] issued_cnt = '0;
  logic [31:0] start_ms = '0;
  logic [31:0] pos_cnt = '0;
  logic moving_fwd = 1'b1;
  logic full_mode = 1'b0;
  logic dir_pin = 1'b1;

  // step reports still owed by the block, oldest first
  vspg_pkg::result_t step_reports_q[$];

  // running millisecond clock for well-formed poll and restart sequences, starts near the wrap
  logic [31:0] now_cur = 32'hFFFF_F000;

  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;

  velocity_step_pulse_generator_top #(
    .MICROSTEPS_PER_FULL(MICROSTEPS)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .operation_i        (operation_i),
    .now_ms_i           (now_ms_i),
    .position_value_i   (position_value_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .step_pulse_o       (step_pulse_o),
    .dir_level_o        (dir_level_o),
    .microstep_select_o (microstep_select_o),
    .position_o         (position_o)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // one microstep or one full step; the pin moves only on a change of direction
  function automatic void take_step(input logic fwd, input logic full);
    logic [31:0] amount;
    amount = full ? MICROSTEPS : 32'd1;
    full_mode = full;
    if (fwd != moving_fwd) begin
      moving_fwd = fwd;
      dir_pin = polarity_reg ? fwd : !fwd;
    end
    if (fwd) begin
      pos_cnt = pos_cnt + amount;
      issued_cnt = issued_cnt + amount;
    end else begin
      pos_cnt = pos_cnt - amount;
      issued_cnt = issued_cnt - amount;
    end
  endfunction

  // advance the motion state by one command and return the report it produces
  function automatic vspg_pkg::result_t advance_stepper(input logic [1:0] op,
                                                        input logic [31:0] tnow,
                                                        input logic [31:0] load_val);
    vspg_pkg::result_t rep;
    longint spd;
    longint elapsed;
    longint owed;
    longint issued;
    longint lim;
    logic fast;
    logic pulse;
    pulse = 1'b0;
    if (op == vspg_pkg::OP_POLL) begin
      spd = speed_reg;
      // elapsed time wraps modulo 2^32 and is taken unsigned
      elapsed = {32'd0, tnow - start_ms};
      owed = spd * elapsed;
      issued = signed'(issued_cnt);
      fast = (speed_reg > vspg_pkg::FAST_POS_Q8) || (speed_reg < vspg_pkg::FAST_NEG_Q8);
      lim = fast ? FULL_LIMIT : 64'sd1;
      // strict on both sides: a surplus of exactly the limit (one microstep or one full step) takes no step
      if (owed < (issued - lim) * MS_Q8_SCALE) begin
        take_step(1'b0, fast);
        pulse = 1'b1;
      end else if (owed > (issued + lim) * MS_Q8_SCALE) begin
        take_step(1'b1, fast);
        pulse = 1'b1;
      end
    end else if (op == vspg_pkg::OP_RESTART) begin
      issued_cnt = '0;
      start_ms = tnow;
    end else if (op == vspg_pkg::OP_LOAD) begin
      pos_cnt = load_val;
    end
    rep.step_pulse = pulse;
    rep.dir_level = dir_pin;
    rep.microstep_select = !full_mode;
    rep.position = pos_cnt;
    return rep;
  endfunction

  // send one command; valid stays high into the next command unless a gap is drawn
  task automatic issue_command(input logic [1:0] op, input logic [31:0] tnow,
                               input logic [31:0] load_val);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    now_ms_i <= tnow;
    position_value_i <= load_val;
    step_reports_q.push_back(advance_stepper(op, tnow, load_val));
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // register writes happen only with nothing in flight
  task automatic write_setting(input vspg_pkg::cfg_reg_e which,
                               input logic [vspg_pkg::SPEED_W-1:0] value);
    in_valid_i <= 1'b0;
    while (step_reports_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= which;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (which == vspg_pkg::CFG_SPEED) begin
      speed_reg = value;
    end else begin
      polarity_reg = value[0];
    end
  endtask

  // speed classes: slow, medium, right at the full-step threshold, fast, extremes, anything
  function automatic logic [vspg_pkg::SPEED_W-1:0] pick_speed();
    int unsigned mag;
    logic [vspg_pkg::SPEED_W-1:0] v;
    case ($urandom_range(0, 5))
      0: mag = $urandom_range(0, 4000);
      1: mag = $urandom_range(4000, 63999);
      2: mag = $urandom_range(63995, 64005);
      3: mag = $urandom_range(64001, 600000);
      4: mag = $urandom_range(8388000, 8388608);
      default: mag = $urandom;
    endcase
    v = mag[vspg_pkg::SPEED_W-1:0];
    if ($urandom_range(0, 1)) begin
      v = -v;
    end
    return v;
  endfunction

  // mostly polls on an advancing clock with restarts mixed in; loads, the spare code and
  // polls at an arbitrary time as noise
  task automatic random_command();
    int pick;
    logic [31:0] tnow;
    pick = $urandom_range(0, 99);
    if (pick < 72) begin
      now_cur = now_cur + $urandom_range(0, 40);
      issue_command(vspg_pkg::OP_POLL, now_cur, $urandom);
    end else if (pick < 82) begin
      now_cur = now_cur + $urandom_range(0, 5);
      issue_command(vspg_pkg::OP_RESTART, now_cur, $urandom);
    end else if (pick < 90) begin
      issue_command(vspg_pkg::OP_LOAD, $urandom, $urandom);
    end else if (pick < 94) begin
      issue_command(OP_SPARE, $urandom, $urandom);
    end else begin
      tnow = $urandom;
      issue_command(vspg_pkg::OP_POLL, tnow, $urandom);
    end
  endtask

  // threshold, wrap and direction cases
  task automatic test_directed_cases();
    snd_idle_pct = 0;
    rcv_stall_pct = 0;
    // reset setting: zero speed never steps, the spare code changes nothing
    issue_command(vspg_pkg::OP_POLL, 32'h0000_0000, 32'h0000_0000);
    issue_command(OP_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue_command(vspg_pkg::OP_LOAD, 32'h1234_5678, 32'h7FFF_FFFF);
    // one microstep per second: exactly 1000 ms owes one step and takes none, 1001 ms steps;
    // the restart sits just below the time wrap and the step wraps the position
    write_setting(vspg_pkg::CFG_SPEED, 24'd256);
    issue_command(vspg_pkg::OP_RESTART, 32'hFFFF_FF00, 32'h0);
    issue_command(vspg_pkg::OP_POLL, 32'h0000_02E8, 32'h0);
    issue_command(vspg_pkg::OP_POLL, 32'h0000_02E9, 32'h0);
    // slow reverse at the threshold itself, inverted direction pin, position wraps back
    write_setting(vspg_pkg::CFG_SPEED, -24'sd64000);
    write_setting(vspg_pkg::CFG_POLARITY, 24'd0);
    issue_command(vspg_pkg::OP_RESTART, 32'h0000_0000, 32'h0);
    issue_command(vspg_pkg::OP_POLL, 32'd5, 32'h0);
    issue_command(vspg_pkg::OP_LOAD, 32'hFFFF_FFFF, 32'h8000_0000);
    issue_command(vspg_pkg::OP_POLL, 32'd1000, 32'h0);
    // just past the threshold: full steps
    write_setting(vspg_pkg::CFG_SPEED, -24'sd64001);
    issue_command(vspg_pkg::OP_RESTART, 32'd100, 32'h0);
    issue_command(vspg_pkg::OP_POLL, 32'd100, 32'h0);
    issue_command(vspg_pkg::OP_POLL, 32'd200, 32'h0);
    // reversal with inverted polarity, no restart
    write_setting(vspg_pkg::CFG_SPEED, 24'sd64001);
    issue_command(vspg_pkg::OP_POLL, 32'd300, 32'h0);
    // polarity change alone leaves the pin; extreme speeds over the longest elapsed time
    write_setting(vspg_pkg::CFG_POLARITY, 24'd1);
    write_setting(vspg_pkg::CFG_SPEED, 24'h7F_FFFF);
    issue_command(vspg_pkg::OP_RESTART, 32'h0000_0000, 32'h0);
    issue_command(vspg_pkg::OP_POLL, 32'hFFFF_FFFF, 32'h0);
    write_setting(vspg_pkg::CFG_SPEED, 24'h80_0000);
    issue_command(vspg_pkg::OP_POLL, 32'hFFFF_FFFF, 32'h0);
    issue_command(OP_SPARE, 32'h0000_0000, 32'h0000_0000);
    write_setting(vspg_pkg::CFG_SPEED, 24'sd64000);
    issue_command(vspg_pkg::OP_RESTART, 32'h0000_0000, 32'h0);
    issue_command(vspg_pkg::OP_POLL, 32'd1000, 32'h0);
    issue_command(vspg_pkg::OP_LOAD, 32'h0000_0000, 32'h0000_0000);
  endtask

  // random commands in four register settings at the given idling rates
  task automatic test_random_traffic(input int snd_pct, input int rcv_pct, input int n_items);
    logic [vspg_pkg::SPEED_W-1:0] pol_word;
    snd_idle_pct = snd_pct;
    rcv_stall_pct = rcv_pct;
    for (int blk = 0; blk < 4; blk++) begin
      write_setting(vspg_pkg::CFG_SPEED, pick_speed());
      pol_word = $urandom;
      write_setting(vspg_pkg::CFG_POLARITY, pol_word);
      // occasionally jump the clock anywhere so all its bits move
      if ($urandom_range(0, 1)) begin
        now_cur = $urandom;
      end
      for (int i = 0; i < n_items / 4; i++) begin
        random_command();
      end
    end
  endtask

  // the sender holds off until every report is back, then resumes
  task automatic test_drain_hold();
    snd_idle_pct = 0;
    rcv_stall_pct = 50;
    write_setting(vspg_pkg::CFG_SPEED, pick_speed());
    for (int i = 0; i < 20; i++) begin
      random_command();
    end
    in_valid_i <= 1'b0;
    while (step_reports_q.size() != 0) @(posedge clk_i);
    for (int i = 0; i < 20; i++) begin
      random_command();
    end
  endtask

  // receiver stall, redrawn every cycle
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < rcv_stall_pct);
  end

  // compare each accepted report with the oldest prediction
  always @(posedge clk_i) begin : check_reports
    vspg_pkg::result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (step_reports_q.size() == 0) begin
        $error("report with no command outstanding: pulse %0b dir %0b micro %0b pos %h",
               step_pulse_o, dir_level_o, microstep_select_o, position_o);
        mismatch_count++;
      end else begin
        want = step_reports_q.pop_front();
        if (step_pulse_o !== want.step_pulse) begin
          $error("step_pulse: expected %0b, actual %0b", want.step_pulse, step_pulse_o);
          mismatch_count++;
        end
        if (dir_level_o !== want.dir_level) begin
          $error("dir_level: expected %0b, actual %0b", want.dir_level, dir_level_o);
          mismatch_count++;
        end
        if (microstep_select_o !== want.microstep_select) begin
          $error("microstep_select: expected %0b, actual %0b", want.microstep_select,
                 microstep_select_o);
          mismatch_count++;
        end
        if (position_o !== want.position) begin
          $error("position: expected %h, actual %h", want.position, position_o);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog: any transaction on either data channel restarts the count
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_cases();
    // no idling, sender gaps, receiver stalls, then both
    test_random_traffic(0, 0, 330);
    test_random_traffic(81, 0, 330);
    test_random_traffic(0, 81, 330);
    test_random_traffic(21, 21, 330);
    test_drain_hold();
    in_valid_i <= 1'b0;
    while (step_reports_q.size() != 0) @(posedge clk_i);
    // catch any stray report after the last one
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/vspg_pkg.sv
rtl/vspg_core.sv
rtl/velocity_step_pulse_generator_top.sv
tb/sv/velocity_step_pulse_generator_top_tb.sv
